FILE: rtl/kuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants for the union-find edge merge block: result
// widths, the saturation limit of the running total and the register map.
// ----------------------------------------------------------------------------
package kuf_pkg;

    localparam int COUNT_W    = 11;
    localparam int TOTAL_W    = 48;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 2;
    localparam int OUT_DATA_W = 64;

    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [TOTAL_W-1:0]    t_total;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [PADDR_W-1:0]    t_paddr;

    localparam t_total    TOTAL_MAX          = {TOTAL_W{1'b1}};
    localparam t_count    VERTEX_COUNT_RESET = 11'd1024;
    localparam t_paddr    REG_VERTEX_COUNT   = 2'd0;

endpackage

FILE: rtl/kruskal_union_find_edge_merge_top.sv
`timescale 1ns / 1ps
// Each edge passes a range check, then for each endpoint a walk up its parent chain and a
// compression walk of that chain, then two link writes if the edge merges; an out-of-range
// edge goes from the check straight to the result. One edge is in work at a time; the
// next is taken in the cycle after its result is written into a free output register.
// A restart edge adds a clearing pass over all MAX_VERTICES entries. After reset the
// same pass runs with s_axis_tready low; configuration writes are taken.
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_merge_top
// Kruskal accept step over a union-find forest with union by size and path
// compression, built around one forest memory walked by a small sequencer.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_merge_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int WEIGHT_BITS  = 40,
    localparam int VW          = $clog2(MAX_VERTICES),
    localparam int IN_DATA_W   = ((1 + 2 * VW + WEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // APB configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  kuf_pkg::t_paddr           paddr,
    input  kuf_pkg::t_cfg_data        pwdata,
    output kuf_pkg::t_cfg_data        prdata,
    output logic                      pready,
    // Edge input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: restart, vertex_one, vertex_two, edge_weight (lowest bit up)
    input  logic [IN_DATA_W-1:0]      s_axis_tdata,
    // Result output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: merged, out_of_range, tree_weight, groups_left (lowest bit up)
    output logic [kuf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import kuf_pkg::*;

    localparam int SW      = $clog2(MAX_VERTICES + 1);
    localparam int ENTRY_W = SW + VW;
    localparam int SUM_W   = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;
    localparam int RESET_ACTIVE = (32'(VERTEX_COUNT_RESET) > MAX_VERTICES) ?
                                  MAX_VERTICES : 32'(VERTEX_COUNT_RESET);
    localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);

    localparam logic [2:0] ST_CLEAR      = 3'd0;
    localparam logic [2:0] ST_IDLE       = 3'd1;
    localparam logic [2:0] ST_CHECK      = 3'd2;
    localparam logic [2:0] ST_WALK       = 3'd3;
    localparam logic [2:0] ST_COMP       = 3'd4;
    localparam logic [2:0] ST_LINK_CHILD = 3'd5;
    localparam logic [2:0] ST_LINK_ROOT  = 3'd6;
    localparam logic [2:0] ST_DONE       = 3'd7;

    t_count w_active_count;

    kuf_apb_regs #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_active_count(w_active_count)
    );

    // Forest memory: each entry holds {group size, parent}.
    logic [ENTRY_W-1:0] mem [MAX_VERTICES];
    logic [ENTRY_W-1:0] r_rdata;
    logic               w_we;
    logic [VW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [VW-1:0]      w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    logic [2:0]             r_state, n_state;
    logic                   r_phase, n_phase;
    logic                   r_pending, n_pending;
    logic [VW-1:0]          r_u, n_u;
    logic [VW-1:0]          r_v, n_v;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [VW-1:0]          r_cur, n_cur;
    logic [VW-1:0]          r_root_a, n_root_a;
    logic [VW-1:0]          r_root_b, n_root_b;
    logic [SW-1:0]          r_size_a, n_size_a;
    logic [SW-1:0]          r_size_b, n_size_b;
    logic                   r_merged, n_merged;
    logic                   r_oor, n_oor;
    t_count                 r_groups, n_groups;
    t_total                 r_total, n_total;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data, n_out_data;

    logic [VW-1:0]  w_parent;
    logic [SW-1:0]  w_size;
    logic [VW-1:0]  w_root;
    logic           w_a_smaller;
    logic [SUM_W-1:0] w_sum;
    logic           w_in_accept;
    logic           w_out_range;

    assign w_parent    = r_rdata[VW-1:0];
    assign w_size      = r_rdata[ENTRY_W-1:VW];
    assign w_root      = r_phase ? r_root_b : r_root_a;
    assign w_a_smaller = (r_size_a < r_size_b);
    assign w_sum       = SUM_W'(r_total) + SUM_W'(r_w);
    assign w_out_range = (32'(r_u) >= 32'(w_active_count)) ||
                         (32'(r_v) >= 32'(w_active_count));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_accept   = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_u         = r_u;
        n_v         = r_v;
        n_w         = r_w;
        n_cur       = r_cur;
        n_root_a    = r_root_a;
        n_root_b    = r_root_b;
        n_size_a    = r_size_a;
        n_size_b    = r_size_b;
        n_merged    = r_merged;
        n_oor       = r_oor;
        n_groups    = r_groups;
        n_total     = r_total;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid & ~m_axis_tready;
        w_we        = 1'b0;
        w_waddr     = r_cur;
        w_wdata     = '0;
        w_raddr     = r_cur;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = {SW'(1), r_cur};
                if (r_cur == LAST_VERTEX) begin
                    n_cur     = '0;
                    n_pending = 1'b0;
                    n_state   = r_pending ? ST_CHECK : ST_IDLE;
                end else begin
                    n_cur = r_cur + VW'(1);
                end
            end
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_u = s_axis_tdata[VW:1];
                    n_v = s_axis_tdata[2*VW:VW+1];
                    n_w = s_axis_tdata[2*VW+WEIGHT_BITS:2*VW+1];
                    if (s_axis_tdata[0]) begin
                        n_groups  = w_active_count;
                        n_total   = '0;
                        n_cur     = '0;
                        n_pending = 1'b1;
                        n_state   = ST_CLEAR;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_merged = 1'b0;
                n_oor    = w_out_range;
                n_phase  = 1'b0;
                if (w_out_range) begin
                    n_state = ST_DONE;
                end else begin
                    n_cur   = r_u;
                    w_raddr = r_u;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // r_rdata holds the entry of r_cur; a self parent marks the root.
                if (w_parent == r_cur) begin
                    if (r_phase) begin
                        n_root_b = r_cur;
                        n_size_b = w_size;
                        n_cur    = r_v;
                        w_raddr  = r_v;
                    end else begin
                        n_root_a = r_cur;
                        n_size_a = w_size;
                        n_cur    = r_u;
                        w_raddr  = r_u;
                    end
                    n_state = ST_COMP;
                end else begin
                    n_cur   = w_parent;
                    w_raddr = w_parent;
                end
            end
            ST_COMP: begin
                // Second walk of the same chain, pointing every node at the root.
                if (r_cur == w_root) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_cur   = r_v;
                        w_raddr = r_v;
                        n_state = ST_WALK;
                    end else if (r_root_a == r_root_b) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_LINK_CHILD;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_cur;
                    w_wdata = {w_size, w_root};
                    n_cur   = w_parent;
                    w_raddr = w_parent;
                end
            end
            ST_LINK_CHILD: begin
                w_we = 1'b1;
                if (w_a_smaller) begin
                    w_waddr = r_root_a;
                    w_wdata = {r_size_a, r_root_b};
                end else begin
                    w_waddr = r_root_b;
                    w_wdata = {r_size_b, r_root_a};
                end
                n_state = ST_LINK_ROOT;
            end
            ST_LINK_ROOT: begin
                w_we     = 1'b1;
                w_waddr  = w_a_smaller ? r_root_b : r_root_a;
                w_wdata  = {r_size_a + r_size_b, w_waddr};
                n_merged = 1'b1;
                if (r_groups != '0) begin
                    n_groups = r_groups - COUNT_W'(1);
                end
                if (w_sum > SUM_W'(TOTAL_MAX)) begin
                    n_total = TOTAL_MAX;
                end else begin
                    n_total = w_sum[TOTAL_W-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_groups, r_total, r_oor, r_merged});
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= 1'b0;
            r_pending   <= 1'b0;
            r_cur       <= '0;
            r_groups    <= COUNT_W'(RESET_ACTIVE);
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_cur       <= n_cur;
            r_groups    <= n_groups;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_v        <= n_v;
        r_w        <= n_w;
        r_root_a   <= n_root_a;
        r_root_b   <= n_root_b;
        r_size_a   <= n_size_a;
        r_size_b   <= n_size_b;
        r_merged   <= n_merged;
        r_oor      <= n_oor;
        r_out_data <= n_out_data;
    end

endmodule

FILE: rtl/kuf_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_apb_regs
// Configuration register file on an APB-style port. Holds the vertex count and
// provides the count in use, clamped to the vertex capacity of the forest.
// ----------------------------------------------------------------------------
module kuf_apb_regs #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  kuf_pkg::t_paddr    paddr,
    input  kuf_pkg::t_cfg_data pwdata,
    output kuf_pkg::t_cfg_data prdata,
    output logic               pready,
    output kuf_pkg::t_count    o_active_count
);
    import kuf_pkg::*;

    t_count r_vertex_count;
    logic   w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite & pready & (paddr == REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (w_write) begin
            r_vertex_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == REG_VERTEX_COUNT) begin
            prdata = CFG_DATA_W'(r_vertex_count);
        end else begin
            prdata = '0;
        end
    end

    // A count beyond the forest capacity is used as the capacity itself.
    always_comb begin
        if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            o_active_count = COUNT_W'(MAX_VERTICES);
        end else begin
            o_active_count = r_vertex_count;
        end
    end

endmodule
